>>> rtl/pcvt_pkg.sv
// Shared types, coefficient table and fixed-point helper for the color vision transform.
package pcvt_pkg;

	localparam int unsigned CH_W = 8;
	localparam int unsigned COEF_FRAC_BITS_DEF = 16;
	localparam int unsigned NUM_ROWS = 8;
	localparam longint DEC_SCALE = 64'sd100000000;

	// Row codes: two weighting rows, then three rows per matrix
	localparam int unsigned ROW_S1 = 0;
	localparam int unsigned ROW_S2 = 1;
	localparam int unsigned ROW_M1 = 2;
	localparam int unsigned ROW_M2 = 5;

	// Coefficients in units of 1e-8, three per row
	localparam longint DEC_COEF [NUM_ROWS*3] = '{
		64'sd999000, 64'sd6647390, 64'sd73170000,
		64'sd15338400, 64'sd31662400, 64'sd5713400,
		64'sd42633100, 64'sd87510200, 64'sd8012710,
		64'sd28110000, 64'sd57119500, -64'sd3926270,
		-64'sd1770520, 64'sd2700840, 64'sd100247000,
		64'sd75810000, 64'sd145387000, -64'sd148060000,
		64'sd11853200, 64'sd28759500, 64'sd72550100,
		-64'sd746579, 64'sd4487110, 64'sd95430300
	};

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
	} pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic            first_matrix_used;
	} result_t;

	// Load enables for the product and sum stages of a dot-product row
	typedef struct packed {
		logic prod;
		logic sum;
	} stage_en_t;

	// Decimal coefficient to signed fixed point, halves away from zero
	function automatic longint to_fixed(input longint dec, input int unsigned frac_bits);
		longint mag;
		longint q;
		mag = (dec < 0) ? -dec : dec;
		q = (mag * (64'sd1 <<< frac_bits) + DEC_SCALE / 2) / DEC_SCALE;
		return (dec < 0) ? -q : q;
	endfunction

endpackage

>>> rtl/palette_color_vision_transform_unit.sv
// Top level of the palette color vision transform: four-stage RGB matrix pipeline.
// One RGB request enters per cycle while result_ready keeps the pipe moving; it passes the
// input register, constant-coefficient products, row sums, then compare/select/round/saturate
// into the output register. Eight dot-product rows run in parallel: two weighting rows S1
// and S2 and the three rows of each color matrix. S1 < S2 selects the first matrix and sets
// first_matrix_used; equal sums take the second. Each channel is rounded to nearest with
// halves away from zero and clamped to 0..255. Every stage has its own valid bit and loads
// whenever it is empty or its successor moves, so bubbles are squeezed out under back
// pressure and a stalled result never loses or repeats a request. COEF_FRAC_BITS sets the
// fractional precision of the coefficients (10..24).
module palette_color_vision_transform_unit #(
	parameter int unsigned COEF_FRAC_BITS = pcvt_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pixel_valid,
	output logic              pixel_ready,
	input  pcvt_pkg::pixel_t  pixel,
	output logic              result_valid,
	input  logic              result_ready,
	output pcvt_pkg::result_t result
);
	import pcvt_pkg::*;

	// Row sums need the product width plus two bits of growth
	localparam int unsigned SUM_W = COEF_FRAC_BITS + 13;
	localparam int unsigned INT_W = SUM_W - 1 - COEF_FRAC_BITS;
	localparam logic [INT_W-1:0] CH_MAX = INT_W'((1 << CH_W) - 1);

	// Per-stage valid bits and load enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4 = !v_s4 || result_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pixel_ready = en1;
	assign result_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= pixel_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: capture the request
	pixel_t pix_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			pix_s1 <= pixel;
		end
	end

	// Stages 2 and 3: eight dot-product rows
	stage_en_t row_en;
	logic signed [SUM_W-1:0] row_sum_s3 [NUM_ROWS];

	assign row_en.prod = en2;
	assign row_en.sum  = en3;

	for (genvar i = 0; i < NUM_ROWS; i++) begin : g_row
		pcvt_dot3 #(
			.COEF_FRAC_BITS(COEF_FRAC_BITS),
			.ROW(i),
			.SUM_W(SUM_W)
		) u_dot3 (
			.clk(clk),
			.en(row_en),
			.red(pix_s1.red_in),
			.green(pix_s1.green_in),
			.blue(pix_s1.blue_in),
			.sum_s3(row_sum_s3[i])
		);
	end

	// Stage 4: pick the matrix, round (offset already in the sums) and clamp
	logic first;
	logic [CH_W-1:0] chan [3];

	assign first = row_sum_s3[ROW_S1] < row_sum_s3[ROW_S2];

	for (genvar k = 0; k < 3; k++) begin : g_chan
		logic signed [SUM_W-1:0] sel;
		logic [INT_W-1:0] whole;

		assign sel   = first ? row_sum_s3[ROW_M1 + k] : row_sum_s3[ROW_M2 + k];
		assign whole = sel[SUM_W-2:COEF_FRAC_BITS];

		always_comb begin
			if (sel[SUM_W-1]) begin
				chan[k] = '0;        // negative sum rounds below zero, clamp to 0
			end else if (whole > CH_MAX) begin
				chan[k] = '1;
			end else begin
				chan[k] = whole[CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			result.red_out           <= chan[0];
			result.green_out         <= chan[1];
			result.blue_out          <= chan[2];
			result.first_matrix_used <= first;
		end
	end

endmodule

>>> rtl/pcvt_dot3.sv
// One constant-coefficient dot product of an RGB triple: product stage, then sum stage.
module pcvt_dot3 #(
	parameter int unsigned COEF_FRAC_BITS = pcvt_pkg::COEF_FRAC_BITS_DEF,
	parameter int unsigned ROW = 0,
	parameter int unsigned SUM_W = COEF_FRAC_BITS + 13
) (
	input  logic                    clk,
	input  pcvt_pkg::stage_en_t     en,
	input  logic [pcvt_pkg::CH_W-1:0] red,
	input  logic [pcvt_pkg::CH_W-1:0] green,
	input  logic [pcvt_pkg::CH_W-1:0] blue,
	output logic signed [SUM_W-1:0] sum_s3
);
	import pcvt_pkg::*;

	localparam int unsigned CW = COEF_FRAC_BITS + 2;
	localparam int unsigned PW = CW + CH_W + 1;
	localparam logic signed [CW-1:0] C_R = CW'(to_fixed(DEC_COEF[ROW*3], COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_G = CW'(to_fixed(DEC_COEF[ROW*3+1], COEF_FRAC_BITS));
	localparam logic signed [CW-1:0] C_B = CW'(to_fixed(DEC_COEF[ROW*3+2], COEF_FRAC_BITS));
	// Half an output LSB; added to every row so the compare rows stay comparable
	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(64'sd1 <<< (COEF_FRAC_BITS - 1));

	logic signed [PW-1:0] prod_r_s2, prod_g_s2, prod_b_s2;

	// Operands widened to the product width before the multiply
	always_ff @(posedge clk) begin
		if (en.prod) begin
			prod_r_s2 <= PW'(C_R) * PW'($signed({1'b0, red}));
			prod_g_s2 <= PW'(C_G) * PW'($signed({1'b0, green}));
			prod_b_s2 <= PW'(C_B) * PW'($signed({1'b0, blue}));
		end
	end

	always_ff @(posedge clk) begin
		if (en.sum) begin
			sum_s3 <= SUM_W'(prod_r_s2) + SUM_W'(prod_g_s2) + SUM_W'(prod_b_s2) + HALF;
		end
	end

endmodule
